// ===== rtl/core/psc_pkg.sv =====
// shared types and constants of the pending signal controller
package psc_pkg;

   localparam int SEQ_W = 64;
   localparam int SET_W = 64;
   localparam int ID_W  = 32;
   localparam int SIG_W = 6;
   localparam int CMD_W = 2;

   localparam int REQ_SN_LSB    = 0;
   localparam int REQ_PID_LSB   = REQ_SN_LSB + SIG_W;
   localparam int REQ_UID_LSB   = REQ_PID_LSB + ID_W;
   localparam int REQ_MASK_LSB  = REQ_UID_LSB + ID_W;
   localparam int REQ_SINCE_LSB = REQ_MASK_LSB + SET_W;
   localparam int REQ_DATA_W    = 200;

   localparam int RSP_SEQ_LSB    = 0;
   localparam int RSP_EDGE_LSB   = RSP_SEQ_LSB + SEQ_W;
   localparam int RSP_ACTIVE_LSB = RSP_EDGE_LSB + SET_W;
   localparam int RSP_FSIG_LSB   = RSP_ACTIVE_LSB + SET_W;
   localparam int RSP_FPID_LSB   = RSP_FSIG_LSB + SIG_W;
   localparam int RSP_FUID_LSB   = RSP_FPID_LSB + ID_W;
   localparam int RSP_DATA_W     = 264;
   localparam int RSP_PAD_W      = RSP_DATA_W - (RSP_FUID_LSB + ID_W);
   localparam int RSP_USER_W     = 2;
   localparam int RSP_FOUND_BIT  = 0;
   localparam int RSP_STATUS_BIT = 1;

   typedef enum logic [CMD_W-1:0] {
      CMD_RAISE = 2'd0,
      CMD_FETCH = 2'd1,
      CMD_POLL  = 2'd2,
      CMD_NOP   = 2'd3
   } cmd_type;

   typedef struct packed {
      logic capture;
      logic ctl_rd;
      logic raise_wr;
      logic scan_inc;
      logic fetch_pop;
      logic rec_load;
      logic stamp_rd;
      logic load_rsp;
   } dp_cmd_type;

   typedef struct packed {
      cmd_type cmd;
      logic    sn_ok;
      logic    scan_hit;
      logic    scan_last;
   } dp_sts_type;

endpackage

// ===== rtl/core/psc_datapath.sv =====
// datapath of the pending signal controller: slot memories, counters and result register
module psc_datapath #(
   parameter int SIGNAL_COUNT = 64,
   parameter int QUEUE_DEPTH  = 4
) (
   input  logic                          clock,
   input  logic                          reset,
   input  psc_pkg::dp_cmd_type           dp_cmd,
   output psc_pkg::dp_sts_type           dp_sts,
   input  logic [psc_pkg::CMD_W-1:0]     req_tuser,
   input  logic [psc_pkg::REQ_DATA_W-1:0] req_tdata,
   output logic [psc_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic [psc_pkg::RSP_USER_W-1:0] rsp_tuser
);
   import psc_pkg::*;

   localparam int SIDX_W    = $clog2(SIGNAL_COUNT);
   localparam int HD_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W     = $clog2(QUEUE_DEPTH + 1);
   localparam int CTL_W     = HD_W + CNT_W;
   localparam int SUM_W     = ((HD_W > CNT_W) ? HD_W : CNT_W) + 1;
   localparam int REC_DEPTH = SIGNAL_COUNT * QUEUE_DEPTH;
   localparam int REC_AW    = $clog2(REC_DEPTH);
   localparam logic [SIG_W:0] SN_LIMIT = (SIG_W + 1)'(SIGNAL_COUNT);

   cmd_type                 cmd_ff;
   logic [SIG_W-1:0]        sn_ff;
   logic [ID_W-1:0]         pid_ff;
   logic [ID_W-1:0]         uid_ff;
   logic [SIGNAL_COUNT-1:0] mask_ff;
   logic [SEQ_W-1:0]        since_ff;
   logic [SIDX_W-1:0]       slot_ff;

   logic [SEQ_W-1:0]        seq_ff, seq_in;
   logic [SIGNAL_COUNT-1:0] active_ff, active_in;
   logic [SIGNAL_COUNT-1:0] edge_ff;

   logic [SEQ_W-1:0]        stamp_mem [SIGNAL_COUNT];
   logic [SIGNAL_COUNT-1:0] stamp_vld_ff, stamp_vld_in;
   logic [SEQ_W-1:0]        stamp_rd_ff;
   logic                    stamp_rd_vld_ff;
   logic                    stamp_pend_ff;
   logic [SIDX_W-1:0]       stamp_idx_ff;

   logic [CTL_W-1:0]        ctl_mem [SIGNAL_COUNT];
   logic [SIGNAL_COUNT-1:0] ctl_vld_ff, ctl_vld_in;
   logic [CTL_W-1:0]        ctl_rd_ff;
   logic                    ctl_rd_vld_ff;

   logic [2*ID_W-1:0]       rec_mem [REC_DEPTH];
   logic [2*ID_W-1:0]       rec_rd_ff;

   logic                    found_ff;
   logic [SIG_W-1:0]        fsig_ff;
   logic [ID_W-1:0]         fpid_ff;
   logic [ID_W-1:0]         fuid_ff;
   logic                    status_ff;
   logic [RSP_DATA_W-1:0]   rsp_data_ff;
   logic [RSP_USER_W-1:0]   rsp_user_ff;

   logic [HD_W-1:0]         ctl_head;
   logic [CNT_W-1:0]        ctl_count;
   logic                    q_full;
   logic [SUM_W-1:0]        pos_sum;
   logic [SUM_W-1:0]        tail_sum;
   logic [HD_W-1:0]         head_nxt;
   logic [HD_W-1:0]         rec_pos;
   logic [REC_AW-1:0]       rec_addr;
   logic [SEQ_W-1:0]        seq_inc;
   logic [SEQ_W-1:0]        stamp_val;

   // slot bookkeeping read back from the control memory
   assign ctl_head  = ctl_rd_vld_ff ? ctl_rd_ff[CTL_W-1 -: HD_W] : '0;
   assign ctl_count = ctl_rd_vld_ff ? ctl_rd_ff[CNT_W-1:0] : '0;
   assign q_full    = ctl_count >= CNT_W'(QUEUE_DEPTH);
   assign pos_sum   = SUM_W'(ctl_head) + SUM_W'(ctl_count);
   assign tail_sum  = (pos_sum >= SUM_W'(QUEUE_DEPTH)) ? pos_sum - SUM_W'(QUEUE_DEPTH) : pos_sum;
   assign head_nxt  = (ctl_head == HD_W'(QUEUE_DEPTH - 1)) ? '0 : ctl_head + 1'b1;
   assign rec_pos   = dp_cmd.raise_wr ? tail_sum[HD_W-1:0] : ctl_head;
   assign rec_addr  = REC_AW'(slot_ff) * REC_AW'(QUEUE_DEPTH) + REC_AW'(rec_pos);
   assign seq_inc   = seq_ff + 1'b1;
   assign stamp_val = stamp_rd_vld_ff ? stamp_rd_ff : '0;

   assign dp_sts.cmd       = cmd_ff;
   assign dp_sts.sn_ok     = {1'b0, sn_ff} < SN_LIMIT;
   assign dp_sts.scan_hit  = mask_ff[slot_ff] & active_ff[slot_ff];
   assign dp_sts.scan_last = slot_ff == SIDX_W'(SIGNAL_COUNT - 1);

   always_comb begin
      seq_in       = seq_ff;
      active_in    = active_ff;
      stamp_vld_in = stamp_vld_ff;
      ctl_vld_in   = ctl_vld_ff;
      if (dp_cmd.raise_wr) begin
         seq_in                = seq_inc;
         stamp_vld_in[slot_ff] = 1'b1;
         if (!q_full) begin
            active_in[slot_ff]  = 1'b1;
            ctl_vld_in[slot_ff] = 1'b1;
         end
      end
      if (dp_cmd.fetch_pop && ctl_count == CNT_W'(1)) begin
         active_in[slot_ff] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff        <= SEQ_W'(1);
         active_ff     <= '0;
         stamp_vld_ff  <= '0;
         ctl_vld_ff    <= '0;
         stamp_pend_ff <= 1'b0;
      end else begin
         seq_ff        <= seq_in;
         active_ff     <= active_in;
         stamp_vld_ff  <= stamp_vld_in;
         ctl_vld_ff    <= ctl_vld_in;
         stamp_pend_ff <= dp_cmd.stamp_rd;
      end
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.capture) begin
         cmd_ff    <= cmd_type'(req_tuser);
         sn_ff     <= req_tdata[REQ_SN_LSB +: SIG_W];
         pid_ff    <= req_tdata[REQ_PID_LSB +: ID_W];
         uid_ff    <= req_tdata[REQ_UID_LSB +: ID_W];
         mask_ff   <= req_tdata[REQ_MASK_LSB +: SIGNAL_COUNT];
         since_ff  <= req_tdata[REQ_SINCE_LSB +: SEQ_W];
         slot_ff   <= (cmd_type'(req_tuser) == CMD_RAISE) ?
                      SIDX_W'(req_tdata[REQ_SN_LSB +: SIG_W]) : '0;
         edge_ff   <= '0;
         found_ff  <= 1'b0;
         fsig_ff   <= '0;
         fpid_ff   <= '0;
         fuid_ff   <= '0;
         status_ff <= 1'b0;
      end else if (dp_cmd.scan_inc) begin
         slot_ff <= slot_ff + 1'b1;
      end

      if (dp_cmd.ctl_rd) begin
         ctl_rd_ff     <= ctl_mem[slot_ff];
         ctl_rd_vld_ff <= ctl_vld_ff[slot_ff];
      end

      if (dp_cmd.raise_wr) begin
         stamp_mem[slot_ff] <= seq_inc;
         if (q_full) begin
            status_ff <= 1'b1;
         end else begin
            rec_mem[rec_addr] <= {uid_ff, pid_ff};
            ctl_mem[slot_ff]  <= {ctl_head, ctl_count + 1'b1};
         end
      end

      if (dp_cmd.fetch_pop) begin
         rec_rd_ff        <= rec_mem[rec_addr];
         ctl_mem[slot_ff] <= {head_nxt, ctl_count - 1'b1};
      end

      if (dp_cmd.rec_load) begin
         found_ff <= 1'b1;
         fsig_ff  <= SIG_W'(slot_ff);
         fpid_ff  <= rec_rd_ff[ID_W-1:0];
         fuid_ff  <= rec_rd_ff[2*ID_W-1:ID_W];
      end

      // stamp compare runs in the cycle after the stamp read
      if (dp_cmd.stamp_rd) begin
         stamp_rd_ff     <= stamp_mem[slot_ff];
         stamp_rd_vld_ff <= stamp_vld_ff[slot_ff];
         stamp_idx_ff    <= slot_ff;
      end
      if (stamp_pend_ff) begin
         edge_ff[stamp_idx_ff] <= stamp_val > since_ff;
      end

      if (dp_cmd.load_rsp) begin
         rsp_data_ff <= {{RSP_PAD_W{1'b0}}, fuid_ff, fpid_ff, fsig_ff,
                         SET_W'(active_ff), SET_W'(edge_ff), seq_ff};
         rsp_user_ff <= {status_ff, found_ff};
      end
   end

   assign rsp_tdata = rsp_data_ff;
   assign rsp_tuser = rsp_user_ff;

endmodule

// ===== rtl/core/psc_ctrl.sv =====
// controller state machine of the pending signal controller
module psc_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output psc_pkg::dp_cmd_type dp_cmd,
   input  psc_pkg::dp_sts_type dp_sts
);
   import psc_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_RAISE_WR,
      ST_FETCH_SCAN,
      ST_FETCH_POP,
      ST_FETCH_LOAD,
      ST_POLL_SCAN,
      ST_POLL_LAST,
      ST_DONE
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_tvalid_ff;
   logic      rsp_free;

   assign rsp_free   = !rsp_tvalid_ff || rsp_tready;
   assign req_tready = state_ff == ST_IDLE;
   assign rsp_tvalid = rsp_tvalid_ff;

   always_comb begin
      state_in = state_ff;
      dp_cmd   = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               dp_cmd.capture = 1'b1;
               state_in       = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            unique case (dp_sts.cmd)
               CMD_RAISE: begin
                  if (dp_sts.sn_ok) begin
                     dp_cmd.ctl_rd = 1'b1;
                     state_in      = ST_RAISE_WR;
                  end else begin
                     state_in = ST_DONE;
                  end
               end
               CMD_FETCH: state_in = ST_FETCH_SCAN;
               CMD_POLL:  state_in = ST_POLL_SCAN;
               default:   state_in = ST_DONE;
            endcase
         end
         ST_RAISE_WR: begin
            dp_cmd.raise_wr = 1'b1;
            state_in        = ST_DONE;
         end
         ST_FETCH_SCAN: begin
            if (dp_sts.scan_hit) begin
               dp_cmd.ctl_rd = 1'b1;
               state_in      = ST_FETCH_POP;
            end else if (dp_sts.scan_last) begin
               state_in = ST_DONE;
            end else begin
               dp_cmd.scan_inc = 1'b1;
            end
         end
         ST_FETCH_POP: begin
            dp_cmd.fetch_pop = 1'b1;
            state_in         = ST_FETCH_LOAD;
         end
         ST_FETCH_LOAD: begin
            dp_cmd.rec_load = 1'b1;
            state_in        = ST_DONE;
         end
         ST_POLL_SCAN: begin
            dp_cmd.stamp_rd = 1'b1;
            if (dp_sts.scan_last) begin
               state_in = ST_POLL_LAST;
            end else begin
               dp_cmd.scan_inc = 1'b1;
            end
         end
         ST_POLL_LAST: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (rsp_free) begin
               dp_cmd.load_rsp = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (dp_cmd.load_rsp) begin
            rsp_tvalid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
      end
   end

endmodule

// ===== rtl/core/pending_signal_controller_unit.sv =====
// Pending signal controller: per-slot queues of sender records with raise stamps. One request
// is worked at a time and gives one response; the finished response waits in an output
// register, so the next request is taken while it is still unread. A raise reads the slot's
// control word, then writes the record and stamp. A fetch scans the slots one per cycle from
// slot 0, stops at the first slot that is both masked and active, and pops its oldest record.
// A poll reads the stamp memory one slot per cycle across all slots; a no-operation goes
// straight to the response. No clearing pass is needed after reset.
module pending_signal_controller_unit #(
   parameter int SIGNAL_COUNT = 64,
   parameter int QUEUE_DEPTH  = 4
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // signal_number, sender_pid, sender_uid, signal_mask, since_seq
   input  logic [psc_pkg::REQ_DATA_W-1:0] req_tdata,
   // cmd
   input  logic [psc_pkg::CMD_W-1:0]      req_tuser,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // current_seq, edge_set, active_set, fetched_signal, fetched_pid, fetched_uid
   output logic [psc_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // found, status
   output logic [psc_pkg::RSP_USER_W-1:0] rsp_tuser
);
   import psc_pkg::*;

   dp_cmd_type dp_cmd;
   dp_sts_type dp_sts;

   psc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .dp_cmd     (dp_cmd),
      .dp_sts     (dp_sts)
   );

   psc_datapath #(
      .SIGNAL_COUNT (SIGNAL_COUNT),
      .QUEUE_DEPTH  (QUEUE_DEPTH)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .dp_cmd    (dp_cmd),
      .dp_sts    (dp_sts),
      .req_tuser (req_tuser),
      .req_tdata (req_tdata),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

endmodule

// ===== rtl/core/psc_checker.sv =====
// port checker of the pending signal controller and its bind
module psc_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [psc_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic [psc_pkg::RSP_USER_W-1:0] rsp_tuser
);
   import psc_pkg::*;

   logic found;
   logic status;

   assign found  = rsp_tuser[RSP_FOUND_BIT];
   assign status = rsp_tuser[RSP_STATUS_BIT];

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
   else $error("response dropped while stalled");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata) && $stable(rsp_tuser))
   else $error("response changed while stalled");

   // an empty fetch or any other request carries no record
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !found |->
         rsp_tdata[RSP_FSIG_LSB +: SIG_W] == '0 &&
         rsp_tdata[RSP_FPID_LSB +: ID_W] == '0 &&
         rsp_tdata[RSP_FUID_LSB +: ID_W] == '0)
   else $error("record fields set without a fetched record");

   // only a poll reports edges, only a raise drops, only a fetch finds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (found || status) |->
         !(found && status) && rsp_tdata[RSP_EDGE_LSB +: SET_W] == '0)
   else $error("response mixes results of different requests");

endmodule

bind pending_signal_controller_unit psc_checker u_psc_checker (.*);

// ===== tb/tb_pending_signal_controller_unit.sv =====
// self-checking testbench for the pending signal controller unit with a request-level predictor
`timescale 1ns / 100ps

module tb_pending_signal_controller_unit;
   import psc_pkg::*;

   localparam int SLOTS       = 64;
   localparam int DEPTH       = 4;
   localparam int RANDOM_REQS = 1300;
   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int DRAIN_WAIT  = 80;

   typedef struct packed {
      cmd_type     cmd;
      logic [5:0]  sn;
      logic [31:0] pid;
      logic [31:0] uid;
      logic [63:0] mask;
      logic [63:0] since;
   } request_type;

   typedef struct packed {
      logic [63:0] seq;
      logic [63:0] edges;
      logic [63:0] active;
      logic        found;
      logic [5:0]  fsig;
      logic [31:0] fpid;
      logic [31:0] fuid;
      logic        status;
   } response_type;

   typedef struct packed {
      logic        typed;
      cmd_type     cmd;
      logic [5:0]  sn;
      logic [31:0] pid;
      logic [31:0] uid;
      logic [63:0] operand;
      logic [63:0] want_seq;
      logic [63:0] want_active;
      logic        want_status;
   } table_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [CMD_W-1:0] req_tuser = CMD_NOP;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [RSP_USER_W-1:0] rsp_tuser;

   pending_signal_controller_unit #(
      .SIGNAL_COUNT(SLOTS),
      .QUEUE_DEPTH (DEPTH)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predicted controller state
   logic [63:0] seq_ctr;
   logic [63:0] active_bits;
   logic [63:0] slot_stamp [SLOTS];
   logic [31:0] rec_pid [SLOTS][DEPTH];
   logic [31:0] rec_uid [SLOTS][DEPTH];
   logic [1:0]  slot_head [SLOTS];
   logic [2:0]  slot_count [SLOTS];

   response_type awaited_rsp_q[$];
   bit gaps_on = 1'b1;
   int mismatches = 0;
   int responses_seen = 0;
   int cycle_count = 0;
   int raises = 0, drops = 0, fetch_hits = 0, fetch_misses = 0, polls = 0, nops = 0;

   table_row_type dir_rows [24];

   function automatic response_type apply_request(request_type r);
      response_type o;
      logic [1:0] pos;
      bit hit;
      int sel;
      o = '0;
      hit = 1'b0;
      sel = 0;
      case (r.cmd)
         CMD_RAISE: begin
            raises++;
            seq_ctr = seq_ctr + 64'd1;
            slot_stamp[r.sn] = seq_ctr;
            if (slot_count[r.sn] >= DEPTH) begin
               o.status = 1'b1;
               drops++;
            end else begin
               pos = slot_head[r.sn] + slot_count[r.sn][1:0];
               rec_pid[r.sn][pos] = r.pid;
               rec_uid[r.sn][pos] = r.uid;
               slot_count[r.sn] = slot_count[r.sn] + 3'd1;
               active_bits[r.sn] = 1'b1;
            end
         end
         CMD_FETCH: begin
            for (int s = 0; s < SLOTS; s++) begin
               if (!hit && r.mask[s] && slot_count[s] != 0) begin
                  hit = 1'b1;
                  sel = s;
               end
            end
            if (hit) begin
               fetch_hits++;
               o.found = 1'b1;
               o.fsig = sel[5:0];
               o.fpid = rec_pid[sel][slot_head[sel]];
               o.fuid = rec_uid[sel][slot_head[sel]];
               slot_head[sel] = slot_head[sel] + 2'd1;
               slot_count[sel] = slot_count[sel] - 3'd1;
               if (slot_count[sel] == 0) active_bits[sel] = 1'b0;
            end else begin
               fetch_misses++;
            end
         end
         CMD_POLL: begin
            polls++;
            for (int s = 0; s < SLOTS; s++) o.edges[s] = slot_stamp[s] > r.since;
         end
         default: nops++;
      endcase
      o.seq = seq_ctr;
      o.active = active_bits;
      return o;
   endfunction

   function automatic request_type random_request();
      request_type r;
      int pick;
      r.pid = $urandom;
      r.uid = $urandom;
      r.mask = {$urandom, $urandom};
      r.since = {$urandom, $urandom};
      pick = $urandom_range(99);
      if ($urandom_range(9) < 6) begin
         r.sn = $urandom_range(1) ? 6'($urandom_range(7)) : 6'($urandom_range(63, 56));
      end else begin
         r.sn = 6'($urandom_range(63));
      end
      if (pick < 40) r.cmd = CMD_RAISE;
      else if (pick < 75) r.cmd = CMD_FETCH;
      else if (pick < 94) r.cmd = CMD_POLL;
      else r.cmd = CMD_NOP;
      case ($urandom_range(5))
         0: r.mask = '1;
         1: r.mask = 64'd1 << r.sn;
         2: r.mask = $urandom_range(9) == 0 ? 64'd0 : r.mask;
         3: r.mask = r.mask | (64'd1 << r.sn);
         default: ;
      endcase
      case ($urandom_range(9))
         0, 1: r.since = '0;
         2: r.since = '1;
         3, 4: ;
         default: r.since = {32'd0, $urandom_range(seq_ctr[31:0] + 1)};
      endcase
      return r;
   endfunction

   task automatic send_request(request_type r, bit typed, response_type want);
      logic [REQ_DATA_W-1:0] d;
      response_type predicted;
      d = '0;
      d[REQ_SN_LSB +: SIG_W] = r.sn;
      d[REQ_PID_LSB +: ID_W] = r.pid;
      d[REQ_UID_LSB +: ID_W] = r.uid;
      d[REQ_MASK_LSB +: SET_W] = r.mask;
      d[REQ_SINCE_LSB +: SEQ_W] = r.since;
      while (gaps_on && $urandom_range(99) < 14) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= d;
      req_tuser <= r.cmd;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predicted = apply_request(r);
      awaited_rsp_q.insert(awaited_rsp_q.size(), typed ? want : predicted);
   endtask

   function automatic void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         mismatches++;
         $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
      end
   endfunction

   task automatic check_response();
      response_type want;
      responses_seen++;
      if (awaited_rsp_q.size() == 0) begin
         mismatches++;
         $display("%0t ns: unexpected response, expected none, actual seq %h", $time,
                  rsp_tdata[RSP_SEQ_LSB +: SEQ_W]);
      end else begin
         want = awaited_rsp_q[0];
         awaited_rsp_q.delete(0);
         compare_field("current_seq", want.seq, rsp_tdata[RSP_SEQ_LSB +: SEQ_W]);
         compare_field("edge_set", want.edges, rsp_tdata[RSP_EDGE_LSB +: SET_W]);
         compare_field("active_set", want.active, rsp_tdata[RSP_ACTIVE_LSB +: SET_W]);
         compare_field("found", 64'(want.found), 64'(rsp_tuser[RSP_FOUND_BIT]));
         compare_field("fetched_signal", 64'(want.fsig),
                       64'(rsp_tdata[RSP_FSIG_LSB +: SIG_W]));
         compare_field("fetched_pid", 64'(want.fpid), 64'(rsp_tdata[RSP_FPID_LSB +: ID_W]));
         compare_field("fetched_uid", 64'(want.fuid), 64'(rsp_tdata[RSP_FUID_LSB +: ID_W]));
         compare_field("status", 64'(want.status), 64'(rsp_tuser[RSP_STATUS_BIT]));
      end
   endtask

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t ns: timeout with %0d responses outstanding", $time, awaited_rsp_q.size());
         $display("pending_signal_controller_unit verification failed");
         $finish;
      end
   end

   // response side, with one long hold-off to back up the request side
   initial begin
      int hold_left;
      bit held_once;
      hold_left = 0;
      held_once = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) check_response();
         if (!held_once && responses_seen == 300) begin
            held_once = 1'b1;
            hold_left = 400;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= !(gaps_on && $urandom_range(99) < 14);
         end
      end
   end

   initial begin
      request_type r;
      response_type want;
      seq_ctr = 64'd1;
      active_bits = '0;
      for (int s = 0; s < SLOTS; s++) begin
         slot_stamp[s] = '0;
         slot_head[s] = '0;
         slot_count[s] = '0;
      end
      dir_rows = '{
         '{1'b1, CMD_POLL,  6'd0,  32'h0,        32'h0,        64'h0, 64'd1, 64'h0, 1'b0},
         '{1'b1, CMD_FETCH, 6'd0,  32'h0,        32'h0,        '1,    64'd1, 64'h0, 1'b0},
         '{1'b1, CMD_NOP,   6'd0,  32'h0,        32'h0,        64'h0, 64'd1, 64'h0, 1'b0},
         '{1'b1, CMD_RAISE, 6'd0,  32'h0,        32'h0,        64'h0, 64'd2, 64'h1, 1'b0},
         '{1'b1, CMD_RAISE, 6'd63, 32'hFFFFFFFF, 32'hFFFFFFFF, 64'h0, 64'd3,
           64'h8000_0000_0000_0001, 1'b0},
         '{1'b0, CMD_RAISE, 6'd5,  32'h1,        32'h2,        64'h0, 64'd0, 64'h0, 1'b0},
         '{1'b0, CMD_RAISE, 6'd5,  32'h3,        32'h4,        64'h0, 64'd0, 64'h0, 1'b0},
         '{1'b0, CMD_RAISE, 6'd5,  32'h5,        32'h6,        64'h0, 64'd0, 64'h0, 1'b0},
         '{1'b0, CMD_RAISE, 6'd5,  32'h7,        32'h8,        64'h0, 64'd0, 64'h0, 1'b0},
         '{1'b1, CMD_RAISE, 6'd5,  32'h9,        32'hA,        64'h0, 64'd8,
           64'h8000_0000_0000_0021, 1'b1},
         '{1'b1, CMD_POLL,  6'd0,  32'h0,        32'h0,        '1,    64'd8,
           64'h8000_0000_0000_0021, 1'b0},
         '{1'b0, CMD_POLL,  6'd0,  32'h0,        32'h0,        64'h0, 64'd0, 64'h0, 1'b0},
         '{1'b0, CMD_POLL,  6'd0,  32'h0,        32'h0,        64'h3, 64'd0, 64'h0, 1'b0},
         '{1'b1, CMD_FETCH, 6'd0,  32'h0,        32'h0,        64'h0, 64'd8,
           64'h8000_0000_0000_0021, 1'b0},
         '{1'b0, CMD_FETCH, 6'd0,  32'h0,        32'h0,        64'h8000_0000_0000_0000,
           64'd0, 64'h0, 1'b0},
         '{1'b0, CMD_FETCH, 6'd0,  32'h0,        32'h0,        '1,    64'd0, 64'h0, 1'b0},
         '{1'b0, CMD_FETCH, 6'd0,  32'h0,        32'h0,        64'h20, 64'd0, 64'h0, 1'b0},
         '{1'b0, CMD_FETCH, 6'd0,  32'h0,        32'h0,        64'h20, 64'd0, 64'h0, 1'b0},
         '{1'b0, CMD_FETCH, 6'd0,  32'h0,        32'h0,        64'h20, 64'd0, 64'h0, 1'b0},
         '{1'b0, CMD_FETCH, 6'd0,  32'h0,        32'h0,        64'h20, 64'd0, 64'h0, 1'b0},
         '{1'b1, CMD_FETCH, 6'd0,  32'h0,        32'h0,        '1,    64'd8, 64'h0, 1'b0},
         '{1'b0, CMD_RAISE, 6'd31, 32'hAAAA5555, 32'h5555AAAA, 64'h0, 64'd0, 64'h0, 1'b0},
         '{1'b0, CMD_POLL,  6'd0,  32'h0,        32'h0,        64'h7, 64'd0, 64'h0, 1'b0},
         '{1'b0, CMD_NOP,   6'd63, 32'hFFFFFFFF, 32'hFFFFFFFF, '1,    64'd0, 64'h0, 1'b0}
      };
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_rows[i]) begin
         r.cmd = dir_rows[i].cmd;
         r.sn = dir_rows[i].sn;
         r.pid = dir_rows[i].pid;
         r.uid = dir_rows[i].uid;
         r.mask = dir_rows[i].operand;
         r.since = dir_rows[i].operand;
         want = '0;
         want.seq = dir_rows[i].want_seq;
         want.active = dir_rows[i].want_active;
         want.status = dir_rows[i].want_status;
         send_request(r, dir_rows[i].typed, want);
      end

      for (int i = 0; i < RANDOM_REQS; i++) begin
         gaps_on = !(i >= 500 && i < 800);
         send_request(random_request(), 1'b0, '0);
      end
      gaps_on = 1'b1;
      req_tvalid <= 1'b0;

      while (awaited_rsp_q.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);

      $display("covered %0d raises (%0d dropped on full queues), %0d fetches (%0d empty),",
               raises, drops, fetch_hits + fetch_misses, fetch_misses);
      $display("%0d polls and %0d no-ops; %0d responses checked, final sequence %0d",
               polls, nops, responses_seen, seq_ctr);
      if (mismatches == 0) begin
         $display("pending_signal_controller_unit verification clean");
      end else begin
         $display("pending_signal_controller_unit verification failed");
      end
      $finish;
   end

endmodule
